// ----- hdl/ffra_pkg.sv -----
package ffra_pkg;

  localparam int MaxRegions = 32;
  localparam int IdxW = $clog2(MaxRegions);
  localparam int CntW = $clog2(MaxRegions + 1);

  localparam logic [2:0] KIND_AVAILABLE = 3'd0;
  localparam logic [2:0] KIND_RESERVED  = 3'd1;
  localparam logic [2:0] KIND_KERNEL    = 3'd2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic CFG_RESERVE_BELOW = 1'b0;
  localparam logic CFG_KERNEL_LIMIT  = 1'b1;

  localparam logic [31:0] RESERVE_RESET = 32'h0010_0000;
  localparam logic [31:0] KLIMIT_RESET  = 32'h0040_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [2:0]  region_kind;
    logic [31:0] alloc_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_base;
  } out_item_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [2:0]  kind;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        load;      // append writes the cell at wr_idx
    logic        split;     // split at sel_idx
    logic        mark;      // mark sel_idx kernel
    logic [IdxW-1:0] wr_idx;
    logic [IdxW-1:0] sel_idx;
    logic [31:0] size;
    entry_t      new_entry;
  } cell_ctl_t;

endpackage

// ----- hdl/first_fit_region_allocator_unit.sv -----
// first-fit region allocator
// in_* channel: one item per transfer (clear, append, allocate, no-op);
// out_* channel: exactly one result per item, in order.
// cfg_* channel: index 0 reserve_below, 1 kernel_limit; write while idle.
// each item passes the input transfer, then the commit state, in which a
// chain of 32 cells finds the first fitting available region by a
// priority ripple and each cell loads, inserts a remainder, shifts from
// its neighbor, marks or holds.
// the result is registered at the end of the commit state; a new item is
// taken only in idle once the result slot is free or being emptied, so a
// new item is not taken before the last one has committed.
// reset empties the table (count to zero) and restores the registers;
// entry contents stay undefined until written.
// while out_stall is high with a result valid, the result holds and no new item is taken.
module first_fit_region_allocator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffra_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffra_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);
  import ffra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [31:0]     reserve_r, klimit_r;
  logic            out_valid_r;
  out_item_t       out_r;
  logic            in_acc;

  entry_t          ent [MaxRegions];
  entry_t          prv [MaxRegions];
  logic            fnd [MaxRegions+1];
  logic            hits [MaxRegions];
  cell_ctl_t       ctl;

  logic [IdxW-1:0] sel;
  entry_t          sel_e;
  logic            full;
  out_item_t       res;
  logic            lim_fail;

  assign in_stall  = !(state_r == S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign full      = count_r == CntW'(MaxRegions);

  // cell chain
  assign fnd[0] = 1'b0;
  for (genvar g = 0; g < MaxRegions; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prv[g] = ent[0];
    end else begin : g_rest
      assign prv[g] = ent[g-1];
    end
    ffra_cell u_cell (
      .clk       (clk),
      .my_idx    (IdxW'(g)),
      .in_range  (CntW'(g) < count_r),
      .ctl       (ctl),
      .prev_entry(prv[g]),
      .prev_found(fnd[g]),
      .entry     (ent[g]),
      .found_out (fnd[g+1]),
      .hit       (hits[g])
    );
  end

  // one-hot hit vector to index
  always_comb begin
    sel = '0;
    for (int i = 0; i < MaxRegions; i++) begin
      if (hits[i]) sel = IdxW'(i);
    end
  end
  assign sel_e = ent[sel];
  // end address compared at 65 bits so a high base cannot wrap
  assign lim_fail = ({33'd0, item_r.alloc_size} + {1'b0, sel_e.base}) >
                    {33'd0, klimit_r};

  // decide in the commit cycle
  always_comb begin
    ctl = '0;
    ctl.wr_idx  = count_r[IdxW-1:0];
    ctl.sel_idx = sel;
    ctl.size    = item_r.alloc_size;
    ctl.new_entry.base   = item_r.region_base;
    ctl.new_entry.length = item_r.region_length;
    ctl.new_entry.kind   = (item_r.region_base < {32'd0, reserve_r}) ?
                           KIND_RESERVED : item_r.region_kind;
    res       = '0;
    count_nxt = count_r;
    if (state_r == S_COMMIT) begin
      case (item_r.opcode)
        OP_CLEAR: count_nxt = '0;
        OP_APPEND: begin
          if (full) res.status = ST_FULL;
          else begin
            ctl.load  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_ALLOC: begin
          if (!fnd[MaxRegions]) res.status = ST_NOFIT;
          else if (lim_fail) res.status = ST_LIMIT;
          else if (sel_e.length > {32'd0, item_r.alloc_size} && full)
            res.status = ST_FULL;
          else begin
            ctl.mark       = 1'b1;
            res.alloc_base = sel_e.base[31:0];
            if (sel_e.length > {32'd0, item_r.alloc_size}) begin
              ctl.split = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
        end
        default: res = '0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      reserve_r   <= RESERVE_RESET;
      klimit_r    <= KLIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_COMMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RESERVE_BELOW) reserve_r <= cfg_data;
        else klimit_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
    if (state_r == S_COMMIT) out_r <= res;
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |=> out_valid) else $error("missing result");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxRegions)) else $error("count overflow");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> in_stall) else $error("accept in commit");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(count_r)) else $error("count moved idle");
`endif

endmodule

// ----- hdl/ffra_cell.sv -----
module ffra_cell (
  input  logic                 clk,
  input  logic [ffra_pkg::IdxW-1:0] my_idx,
  input  logic                 in_range,
  input  ffra_pkg::cell_ctl_t  ctl,
  input  ffra_pkg::entry_t     prev_entry,
  input  logic                 prev_found,
  output ffra_pkg::entry_t     entry,
  output logic                 found_out,
  output logic                 hit
);
  import ffra_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   fit;

  // fit test for this cell, first-fit priority passed down the chain
  assign fit = in_range && (entry_r.kind == KIND_AVAILABLE) &&
               (entry_r.length >= {32'd0, ctl.size});
  assign hit = fit && !prev_found;
  assign found_out = prev_found || fit;
  assign entry = entry_r;

  // next entry: load, remainder insert, shift from neighbor, or mark
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load && ctl.wr_idx == my_idx) begin
      entry_nxt = ctl.new_entry;
    end else if (ctl.split && my_idx > ctl.sel_idx) begin
      if (my_idx == ctl.sel_idx + 1'b1) begin
        entry_nxt.base   = prev_entry.base + {32'd0, ctl.size};
        entry_nxt.length = prev_entry.length - {32'd0, ctl.size};
        entry_nxt.kind   = KIND_AVAILABLE;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctl.mark && my_idx == ctl.sel_idx) begin
      entry_nxt.kind = KIND_KERNEL;
      if (ctl.split) entry_nxt.length = {32'd0, ctl.size};
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
